### hdl/albd_pkg.sv
// ----------------------------------------------------------------------------
// albd_pkg
// Types, constants and helpers shared by the ladder button decoder.
// ----------------------------------------------------------------------------
package albd_pkg;

    localparam int MAX_BUTTONS = 6;
    localparam int SAMPLE_W    = 10;
    localparam int TIME_W      = 32;
    localparam int BTN_W       = 3;
    localparam int BCOUNT_W    = 3;
    localparam int LEVELS_W    = MAX_BUTTONS * SAMPLE_W;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = LEVELS_W;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEVELS    = 2'd2;

    localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 10'd30;

    localparam logic [TIME_W-1:0]   IDLE_PERIOD_MS   = 32'd40;
    localparam logic [TIME_W-1:0]   BOUNCE_PERIOD_MS = 32'd5;
    localparam logic [TIME_W-1:0]   LOCKOUT_MS       = 32'd150;
    localparam logic [TIME_W-1:0]   RETRIGGER_MS     = 32'd300;
    localparam logic [BCOUNT_W-1:0] BOUNCE_SAMPLES   = 3'd4;

    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_PRESS   = 2'd1;
    localparam logic [1:0] EV_HOLD    = 2'd2;
    localparam logic [1:0] EV_RELEASE = 2'd3;

    typedef struct packed {
        logic [TIME_W-1:0]   now_ms;
        logic                sample_ready;
        logic [SAMPLE_W-1:0] sample;
        logic                suppress_release;
    } item_t;

    typedef struct packed {
        logic [1:0]        event_kind;
        logic [BTN_W-1:0]  button_index;
        logic [TIME_W-1:0] duration_ms;
        logic              is_down;
        logic              was_down;
    } result_t;

    typedef struct packed {
        logic             hit;
        logic [BTN_W-1:0] idx;
    } match_t;

    function automatic logic [SAMPLE_W-1:0] abs_diff(
        input logic [SAMPLE_W-1:0] a,
        input logic [SAMPLE_W-1:0] b
    );
        logic [SAMPLE_W-1:0] r;
        if (a >= b)
        begin
            r = a - b;
        end
        else
        begin
            r = b - a;
        end
        return r;
    endfunction

endpackage

### hdl/albd_match.sv
// ----------------------------------------------------------------------------
// albd_match
// Parallel window compare against the ladder levels, lowest index wins.
// ----------------------------------------------------------------------------
module albd_match (
    input  logic [albd_pkg::SAMPLE_W-1:0] sample,
    input  logic [albd_pkg::SAMPLE_W-1:0] threshold,
    input  logic [albd_pkg::BTN_W-1:0]    button_count,
    input  logic [albd_pkg::LEVELS_W-1:0] levels,
    output albd_pkg::match_t              match
);
    import albd_pkg::*;

    logic [BTN_W-1:0] count_clamped;

    assign count_clamped = (button_count > BTN_W'(MAX_BUTTONS)) ? BTN_W'(MAX_BUTTONS)
                                                                 : button_count;

    always_comb
    begin
        match.hit = 1'b0;
        match.idx = '0;
        for (int i = MAX_BUTTONS - 1; i >= 0; i--)
        begin
            if ((BTN_W'(i) < count_clamped) &&
                (abs_diff(sample, levels[i*SAMPLE_W +: SAMPLE_W]) < threshold))
            begin
                match.hit = 1'b1;
                match.idx = BTN_W'(i);
            end
        end
    end

endmodule

### hdl/albd_core.sv
// ----------------------------------------------------------------------------
// albd_core
// Decoder state: sample gating, debounce, press/hold/release and lockout.
// ----------------------------------------------------------------------------
module albd_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  albd_pkg::item_t               item,
    input  logic [albd_pkg::SAMPLE_W-1:0] threshold,
    input  albd_pkg::match_t              match,
    output albd_pkg::result_t             result
);
    import albd_pkg::*;

    logic                pressed_reg, pressed_next;
    logic                prev_flag;
    logic [BCOUNT_W-1:0] bcount_reg, bcount_next;
    logic [TIME_W-1:0]   last_time_reg, last_time_next;
    logic [SAMPLE_W-1:0] last_val_reg, last_val_next;
    logic [BTN_W-1:0]    active_reg, active_next;
    logic [TIME_W-1:0]   press_time_reg, press_time_next;
    logic [TIME_W-1:0]   release_time_reg, release_time_next;
    logic                armed_reg, armed_next;

    logic [TIME_W-1:0]   since_sample;
    logic [TIME_W-1:0]   since_press;
    logic [TIME_W-1:0]   since_release;
    logic                gated;
    logic                changed;
    logic [BCOUNT_W-1:0] bcount_eff;
    logic [1:0]          kind;
    logic [TIME_W-1:0]   dur;

    assign since_sample  = item.now_ms - last_time_reg;
    assign since_press   = item.now_ms - press_time_reg;
    assign since_release = item.now_ms - release_time_reg;
    assign gated   = (bcount_reg == '0) ? (since_sample < IDLE_PERIOD_MS)
                                        : (since_sample < BOUNCE_PERIOD_MS);
    assign changed    = abs_diff(item.sample, last_val_reg) > threshold;
    assign bcount_eff = changed ? BCOUNT_W'(1) : bcount_reg;

    // was_down is rebuilt from the pressed state on every tick, and cleared on a suppressed release
    always_comb
    begin
        pressed_next      = pressed_reg;
        prev_flag         = pressed_reg;
        bcount_next       = bcount_reg;
        last_time_next    = last_time_reg;
        last_val_next     = last_val_reg;
        active_next       = active_reg;
        press_time_next   = press_time_reg;
        release_time_next = release_time_reg;
        armed_next        = armed_reg | item.suppress_release;
        kind              = EV_NONE;
        dur               = '0;

        if (!gated && item.sample_ready)
        begin
            last_time_next = item.now_ms;
            last_val_next  = item.sample;
            if (bcount_eff < BOUNCE_SAMPLES)
            begin
                bcount_next = bcount_eff + BCOUNT_W'(1);
            end
            else
            begin
                bcount_next = '0;
                if (match.hit)
                begin
                    if (since_release < LOCKOUT_MS)
                    begin
                        kind = EV_NONE;
                    end
                    else if (((active_reg != match.idx) && (since_press < RETRIGGER_MS))
                             || !pressed_reg)
                    begin
                        active_next     = match.idx;
                        pressed_next    = 1'b1;
                        press_time_next = item.now_ms;
                        kind            = EV_PRESS;
                        dur             = since_release;
                    end
                    else
                    begin
                        kind = EV_HOLD;
                        dur  = since_press;
                    end
                end
                else if (pressed_reg)
                begin
                    pressed_next      = 1'b0;
                    release_time_next = item.now_ms;
                    if (armed_next)
                    begin
                        prev_flag  = 1'b0;
                        armed_next = 1'b0;
                    end
                    else
                    begin
                        kind = EV_RELEASE;
                        dur  = since_press;
                    end
                end
            end
        end

        result.event_kind   = kind;
        result.button_index = active_next;
        result.duration_ms  = dur;
        result.is_down      = pressed_next;
        result.was_down     = prev_flag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressed_reg      <= 1'b0;
            bcount_reg       <= '0;
            last_time_reg    <= '0;
            last_val_reg     <= '0;
            active_reg       <= '0;
            press_time_reg   <= '0;
            release_time_reg <= '0;
            armed_reg        <= 1'b0;
        end
        else if (step)
        begin
            pressed_reg      <= pressed_next;
            bcount_reg       <= bcount_next;
            last_time_reg    <= last_time_next;
            last_val_reg     <= last_val_next;
            active_reg       <= active_next;
            press_time_reg   <= press_time_next;
            release_time_reg <= release_time_next;
            armed_reg        <= armed_next;
        end
    end

endmodule

### hdl/analog_ladder_button_decoder.sv
// ----------------------------------------------------------------------------
// analog_ladder_button_decoder
// Path: an item is held in the input reg, then moves to the result reg once that is free.
// Throughput: one item per cycle while result_ready is high; the result register frees as it transfers.
// State update and level match are combinational between the two registers.
// Reset: asynchronous, clears state and config (threshold 30, no levels).
// ----------------------------------------------------------------------------
module analog_ladder_button_decoder (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_ready,
    input  albd_pkg::item_t                 item,
    output logic                            result_valid,
    input  logic                            result_ready,
    output albd_pkg::result_t               result,
    input  logic                            cfg_write,
    input  logic [albd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [albd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import albd_pkg::*;

    logic [SAMPLE_W-1:0] threshold_reg;
    logic [BTN_W-1:0]    count_reg;
    logic [LEVELS_W-1:0] levels_reg;

    logic    stage_valid_reg;
    item_t   stage_reg;
    logic    result_valid_reg;
    result_t result_reg;
    result_t result_next;
    match_t  match;
    logic    advance;

    assign advance    = stage_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready = !stage_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            count_reg     <= '0;
            levels_reg    <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_THRESHOLD: threshold_reg <= cfg_data[SAMPLE_W-1:0];
                REG_COUNT:     count_reg     <= cfg_data[BTN_W-1:0];
                REG_LEVELS:    levels_reg    <= cfg_data[LEVELS_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_ready)
            begin
                stage_valid_reg <= item_valid;
            end
            if (advance)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            stage_reg <= item;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    albd_match u_match (
        .sample       (stage_reg.sample),
        .threshold    (threshold_reg),
        .button_count (count_reg),
        .levels       (levels_reg),
        .match        (match)
    );

    albd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .item      (stage_reg),
        .threshold (threshold_reg),
        .match     (match),
        .result    (result_next)
    );

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_stage_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> result_valid)
        else $error("staged item did not reach the result register");

    a_press_down: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.event_kind == EV_PRESS)
            |-> (result.is_down && result.button_index < BTN_W'(MAX_BUTTONS)))
        else $error("press without a valid pressed button");

    a_release_state: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.event_kind == EV_RELEASE)
            |-> (!result.is_down && result.was_down))
        else $error("release with inconsistent pressed state");

    a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.event_kind == EV_HOLD)
            |-> (result.is_down && result.was_down))
        else $error("hold while not pressed");

endmodule
